FILE: rtl/cstrip_pkg.sv
package cstrip_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int ERR_LINE_W    = 16;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        S_TEXT,
        S_SLASH,
        S_COMMENT,
        S_STAR,
        S_CHR,
        S_CHR_ESC,
        S_STR,
        S_STR_ESC
    } t_scan_state;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  is_text;
        logic                  last;
        logic                  unterminated;
        logic [ERR_LINE_W-1:0] error_line;
    } t_result;

    // Results caused by one accepted item, in order: r0 first.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_scan_out;

    function automatic t_result text_result(input logic [7:0] b, input logic lst);
        t_result r;
        r.out_byte     = b;
        r.is_text      = 1'b1;
        r.last         = lst;
        r.unterminated = 1'b0;
        r.error_line   = '0;
        return r;
    endfunction

endpackage

FILE: rtl/cstrip_scan.sv
module cstrip_scan #(
    parameter int LINE_BITS = cstrip_pkg::LINE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_end_of_text,
    output cstrip_pkg::t_scan_out o_res
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    cstrip_pkg::t_scan_state r_state, n_state;
    logic [LINE_BITS-1:0]    r_line, n_line;
    logic [LINE_BITS-1:0]    r_cline, n_cline;
    logic [LINE_BITS-1:0]    w_line_inc;
    logic                    w_unterm;
    logic [7:0]              c;

    assign c = i_in_byte;

    // Newline advances the count before the byte is scanned; saturate at all ones.
    assign w_line_inc = (c == cstrip_pkg::CH_NL && r_line != LINE_MAX) ?
                        r_line + LINE_ONE : r_line;
    assign w_unterm   = (r_state == cstrip_pkg::S_COMMENT) ||
                        (r_state == cstrip_pkg::S_STAR);

    always_comb begin
        n_state = r_state;
        n_line  = w_line_inc;
        n_cline = r_cline;
        if (i_end_of_text) begin
            n_state = cstrip_pkg::S_TEXT;
            n_line  = LINE_ONE;
            n_cline = LINE_ONE;
        end else begin
            case (r_state)
                cstrip_pkg::S_TEXT: begin
                    if (c == cstrip_pkg::CH_SLASH) n_state = cstrip_pkg::S_SLASH;
                    else if (c == cstrip_pkg::CH_QUOTE) n_state = cstrip_pkg::S_CHR;
                    else if (c == cstrip_pkg::CH_DQUOTE) n_state = cstrip_pkg::S_STR;
                end
                cstrip_pkg::S_SLASH: begin
                    if (c == cstrip_pkg::CH_SLASH) begin
                        n_state = cstrip_pkg::S_SLASH;
                    end else if (c == cstrip_pkg::CH_STAR) begin
                        n_state = cstrip_pkg::S_COMMENT;
                        n_cline = w_line_inc;
                    end else if (c == cstrip_pkg::CH_QUOTE) begin
                        n_state = cstrip_pkg::S_CHR;
                    end else if (c == cstrip_pkg::CH_DQUOTE) begin
                        n_state = cstrip_pkg::S_STR;
                    end else begin
                        n_state = cstrip_pkg::S_TEXT;
                    end
                end
                cstrip_pkg::S_COMMENT: begin
                    if (c == cstrip_pkg::CH_STAR) n_state = cstrip_pkg::S_STAR;
                end
                cstrip_pkg::S_STAR: begin
                    if (c == cstrip_pkg::CH_SLASH) n_state = cstrip_pkg::S_TEXT;
                    else if (c != cstrip_pkg::CH_STAR) n_state = cstrip_pkg::S_COMMENT;
                end
                cstrip_pkg::S_CHR: begin
                    if (c == cstrip_pkg::CH_BSLASH) n_state = cstrip_pkg::S_CHR_ESC;
                    else if (c == cstrip_pkg::CH_QUOTE) n_state = cstrip_pkg::S_TEXT;
                end
                cstrip_pkg::S_CHR_ESC: n_state = cstrip_pkg::S_CHR;
                cstrip_pkg::S_STR: begin
                    if (c == cstrip_pkg::CH_BSLASH) n_state = cstrip_pkg::S_STR_ESC;
                    else if (c == cstrip_pkg::CH_DQUOTE) n_state = cstrip_pkg::S_TEXT;
                end
                cstrip_pkg::S_STR_ESC: n_state = cstrip_pkg::S_STR;
                default: n_state = cstrip_pkg::S_TEXT;
            endcase
        end
    end

    always_comb begin
        o_res.count = 2'd0;
        o_res.r0    = cstrip_pkg::text_result(c, 1'b1);
        o_res.r1    = cstrip_pkg::text_result(c, 1'b1);
        if (i_end_of_text) begin
            o_res.r1.out_byte     = '0;
            o_res.r1.is_text      = 1'b0;
            o_res.r1.unterminated = w_unterm;
            o_res.r1.error_line   = w_unterm ? cstrip_pkg::ERR_LINE_W'(r_cline) : '0;
            if (r_state == cstrip_pkg::S_SLASH) begin
                // flush the held slash ahead of the status
                o_res.count = 2'd2;
                o_res.r0    = cstrip_pkg::text_result(cstrip_pkg::CH_SLASH, 1'b0);
            end else begin
                o_res.count = 2'd1;
                o_res.r0    = o_res.r1;
            end
        end else begin
            case (r_state)
                cstrip_pkg::S_TEXT: begin
                    if (c != cstrip_pkg::CH_SLASH) o_res.count = 2'd1;
                end
                cstrip_pkg::S_SLASH: begin
                    if (c == cstrip_pkg::CH_SLASH) begin
                        o_res.count = 2'd1;
                        o_res.r0    = cstrip_pkg::text_result(cstrip_pkg::CH_SLASH, 1'b1);
                    end else if (c == cstrip_pkg::CH_STAR) begin
                        o_res.count = 2'd1;
                        o_res.r0    = cstrip_pkg::text_result(cstrip_pkg::CH_SPACE, 1'b1);
                    end else begin
                        o_res.count = 2'd2;
                        o_res.r0    = cstrip_pkg::text_result(cstrip_pkg::CH_SLASH, 1'b0);
                    end
                end
                cstrip_pkg::S_COMMENT, cstrip_pkg::S_STAR: begin
                    if (c == cstrip_pkg::CH_NL) o_res.count = 2'd1;
                end
                default: o_res.count = 2'd1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cstrip_pkg::S_TEXT;
            r_line  <= LINE_ONE;
            r_cline <= LINE_ONE;
        end else if (i_accept) begin
            r_state <= n_state;
            r_line  <= n_line;
            r_cline <= n_cline;
        end
    end

endmodule

FILE: rtl/cstrip_outq.sv
module cstrip_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  cstrip_pkg::t_scan_out i_res,
    output logic                  o_room,
    output logic                  o_valid,
    input  logic                  i_stall,
    output cstrip_pkg::t_result   o_res
);

    localparam int PW = $clog2(cstrip_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(cstrip_pkg::QUEUE_DEPTH + 1);

    cstrip_pkg::t_result r_mem [cstrip_pkg::QUEUE_DEPTH];
    logic [PW-1:0]       r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       w_push_n;
    logic                w_pop;

    assign w_push_n = i_push ? CW'(i_res.count) : '0;
    assign w_pop    = o_valid && !i_stall;
    assign o_valid  = r_count != '0;
    assign o_res    = r_mem[r_rp];
    // Taken from registers only, so the input side never waits on the output stall.
    assign o_room   = r_count <= CW'(cstrip_pkg::QUEUE_DEPTH - 2);

    assign n_wp    = r_wp + PW'(w_push_n);
    assign n_rp    = r_rp + PW'(w_pop);
    assign n_count = r_count + w_push_n - CW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (w_push_n != '0) r_mem[r_wp] <= i_res.r0;
        if (w_push_n == CW'(2)) r_mem[r_wp + PW'(1)] <= i_res.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/c_comment_stripper_core.sv
// C comment stripper: takes source text one byte per item and replaces each
// block comment with a single space, keeping newlines inside comments and passing
// character and string literals through untouched. A slash is held until the next
// byte shows whether it opens a comment. An item with i_end_of_text set flushes a
// held slash, gives a status result (unterminated flag and the line on which the
// latest comment opened) and returns the block to its reset state. Each item is
// scanned in the cycle it is accepted and its results land in a four-entry output
// queue, so one item is taken every cycle while there is room; the queue drains one
// result per cycle while i_stall is low, so an item with two results (slash flush)
// can briefly hold o_stall high. Line counting saturates at 2**LINE_BITS - 1.
module c_comment_stripper_core #(
    parameter int LINE_BITS = cstrip_pkg::LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_text,
    output logic        o_last,
    output logic        o_unterminated,
    output logic [15:0] o_error_line
);

    cstrip_pkg::t_scan_out w_scan;
    cstrip_pkg::t_result   w_head;
    logic                  w_room;
    logic                  w_accept;

    assign o_stall  = !w_room;
    assign w_accept = i_valid && w_room;

    cstrip_scan #(
        .LINE_BITS (LINE_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_res         (w_scan)
    );

    cstrip_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_res   (w_scan),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_head)
    );

    assign o_out_byte     = w_head.out_byte;
    assign o_is_text      = w_head.is_text;
    assign o_last         = w_head.last;
    assign o_unterminated = w_head.unterminated;
    assign o_error_line   = w_head.error_line;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_PCT    = 28;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;
    localparam int RAND_ITEMS  = 280;
    localparam int CALM_ITEMS  = 80;
    localparam int N_DIR       = 29;

    typedef struct packed {
        logic [7:0]          b;
        logic                eot;
        logic                calm;
        logic                typed;
        logic [1:0]          n;
        cstrip_pkg::t_result r0;
        cstrip_pkg::t_result r1;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_is_text;
    logic        o_last;
    logic        o_unterminated;
    logic [15:0] o_error_line;

    c_comment_stripper_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_is_text      (o_is_text),
        .o_last         (o_last),
        .o_unterminated (o_unterminated),
        .o_error_line   (o_error_line)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // scanner copy used for prediction
    cstrip_pkg::t_scan_state sc_state = cstrip_pkg::S_TEXT;
    logic [15:0] sc_line  = 16'd1;
    logic [15:0] sc_cline = 16'd1;

    cstrip_pkg::t_result step_out[$];
    cstrip_pkg::t_result pending_out[$];
    t_item               feed_q[$];
    t_item               dir_tab[N_DIR];
    t_item               cur;
    logic                no_idle = 1'b0;
    int                  n_fail = 0;
    int                  quiet_cycles = 0;
    cstrip_pkg::t_result got;
    cstrip_pkg::t_result want;

    function automatic cstrip_pkg::t_result mk(input logic [7:0] b, input logic txt,
                                               input logic lst, input logic unt,
                                               input logic [15:0] ln);
        cstrip_pkg::t_result r;
        r.out_byte     = b;
        r.is_text      = txt;
        r.last         = lst;
        r.unterminated = unt;
        r.error_line   = ln;
        return r;
    endfunction

    function automatic t_item row(input logic [7:0] b, input logic eot, input logic typed,
                                  input logic [1:0] n, input cstrip_pkg::t_result r0,
                                  input cstrip_pkg::t_result r1);
        t_item it;
        it.b     = b;
        it.eot   = eot;
        it.calm  = 1'b0;
        it.typed = typed;
        it.n     = n;
        it.r0    = r0;
        it.r1    = r1;
        return it;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = cstrip_pkg::CH_NL;
            1: b = cstrip_pkg::CH_STAR;
            2: b = cstrip_pkg::CH_SLASH;
            3: b = cstrip_pkg::CH_BSLASH;
            4: b = cstrip_pkg::CH_QUOTE;
            5: b = cstrip_pkg::CH_DQUOTE;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    task automatic put_text(input logic [7:0] b);
        step_out.push_back(mk(b, 1'b1, 1'b0, 1'b0, 16'h0000));
    endtask

    // Compute the results of one item and advance the scanner copy.
    task automatic strip_byte(input logic [7:0] c, input logic eot);
        logic                unt;
        cstrip_pkg::t_result tail;
        step_out.delete();
        if (eot) begin
            unt = (sc_state == cstrip_pkg::S_COMMENT || sc_state == cstrip_pkg::S_STAR);
            if (sc_state == cstrip_pkg::S_SLASH)
                put_text(cstrip_pkg::CH_SLASH);
            step_out.push_back(mk(8'h00, 1'b0, 1'b0, unt, unt ? sc_cline : 16'h0000));
            sc_state = cstrip_pkg::S_TEXT;
            sc_line  = 16'd1;
            sc_cline = 16'd1;
        end else begin
            if (c == cstrip_pkg::CH_NL && sc_line != 16'hFFFF)
                sc_line = sc_line + 16'd1;
            case (sc_state)
                cstrip_pkg::S_TEXT: begin
                    if (c == cstrip_pkg::CH_SLASH) begin
                        sc_state = cstrip_pkg::S_SLASH;
                    end else begin
                        if (c == cstrip_pkg::CH_QUOTE) sc_state = cstrip_pkg::S_CHR;
                        else if (c == cstrip_pkg::CH_DQUOTE) sc_state = cstrip_pkg::S_STR;
                        put_text(c);
                    end
                end
                cstrip_pkg::S_SLASH: begin
                    if (c == cstrip_pkg::CH_SLASH) begin
                        put_text(cstrip_pkg::CH_SLASH);
                    end else if (c == cstrip_pkg::CH_STAR) begin
                        sc_cline = sc_line;
                        sc_state = cstrip_pkg::S_COMMENT;
                        put_text(cstrip_pkg::CH_SPACE);
                    end else begin
                        if (c == cstrip_pkg::CH_QUOTE) sc_state = cstrip_pkg::S_CHR;
                        else if (c == cstrip_pkg::CH_DQUOTE) sc_state = cstrip_pkg::S_STR;
                        else sc_state = cstrip_pkg::S_TEXT;
                        put_text(cstrip_pkg::CH_SLASH);
                        put_text(c);
                    end
                end
                cstrip_pkg::S_COMMENT: begin
                    if (c == cstrip_pkg::CH_STAR) sc_state = cstrip_pkg::S_STAR;
                    else if (c == cstrip_pkg::CH_NL) put_text(cstrip_pkg::CH_NL);
                end
                cstrip_pkg::S_STAR: begin
                    if (c == cstrip_pkg::CH_SLASH) begin
                        sc_state = cstrip_pkg::S_TEXT;
                    end else if (c != cstrip_pkg::CH_STAR) begin
                        sc_state = cstrip_pkg::S_COMMENT;
                        if (c == cstrip_pkg::CH_NL) put_text(cstrip_pkg::CH_NL);
                    end
                end
                cstrip_pkg::S_CHR: begin
                    if (c == cstrip_pkg::CH_BSLASH) sc_state = cstrip_pkg::S_CHR_ESC;
                    else if (c == cstrip_pkg::CH_QUOTE) sc_state = cstrip_pkg::S_TEXT;
                    put_text(c);
                end
                cstrip_pkg::S_CHR_ESC: begin
                    sc_state = cstrip_pkg::S_CHR;
                    put_text(c);
                end
                cstrip_pkg::S_STR: begin
                    if (c == cstrip_pkg::CH_BSLASH) sc_state = cstrip_pkg::S_STR_ESC;
                    else if (c == cstrip_pkg::CH_DQUOTE) sc_state = cstrip_pkg::S_TEXT;
                    put_text(c);
                end
                default: begin
                    sc_state = cstrip_pkg::S_STR;
                    put_text(c);
                end
            endcase
        end
        if (step_out.size() > 0) begin
            tail = step_out.pop_back();
            tail.last = 1'b1;
            step_out.push_back(tail);
        end
    endtask

    task automatic add_item(input logic [7:0] b, input logic eot, input logic calm);
        t_item it;
        it = row(b, eot, 1'b0, 2'd0, '0, '0);
        it.calm = calm;
        feed_q.push_back(it);
    endtask

    // Mostly well-formed C fragments with random content, plus some noise and
    // comments that never close.
    task automatic gen_source(input int want_items, input logic calm);
        int base;
        int pick;
        base = feed_q.size();
        while (feed_q.size() - base < want_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                add_item(8'($urandom_range(0, 255)), 1'b0, calm);
            end else if (pick < 45) begin
                add_item(cstrip_pkg::CH_SLASH, 1'b0, calm);
                add_item(cstrip_pkg::CH_STAR, 1'b0, calm);
                repeat ($urandom_range(0, 6)) add_item(body_byte(), 1'b0, calm);
                if ($urandom_range(0, 7) != 0) begin
                    repeat ($urandom_range(1, 2)) add_item(cstrip_pkg::CH_STAR, 1'b0, calm);
                    add_item(cstrip_pkg::CH_SLASH, 1'b0, calm);
                end
            end else if (pick < 55) begin
                add_item(cstrip_pkg::CH_QUOTE, 1'b0, calm);
                if ($urandom_range(0, 2) == 0) add_item(cstrip_pkg::CH_BSLASH, 1'b0, calm);
                add_item(8'($urandom_range(0, 255)), 1'b0, calm);
                add_item(cstrip_pkg::CH_QUOTE, 1'b0, calm);
            end else if (pick < 70) begin
                add_item(cstrip_pkg::CH_DQUOTE, 1'b0, calm);
                repeat ($urandom_range(0, 6)) add_item(body_byte(), 1'b0, calm);
                add_item(cstrip_pkg::CH_DQUOTE, 1'b0, calm);
            end else if (pick < 80) begin
                add_item(cstrip_pkg::CH_SLASH, 1'b0, calm);
                add_item($urandom_range(0, 1) ? cstrip_pkg::CH_SLASH : body_byte(), 1'b0, calm);
            end else if (pick < 90) begin
                add_item(cstrip_pkg::CH_NL, 1'b0, calm);
            end else if (pick < 95) begin
                add_item(8'($urandom_range(0, 255)), 1'b1, calm);
            end else begin
                add_item(body_byte(), 1'b0, calm);
            end
        end
        add_item(8'($urandom_range(0, 255)), 1'b1, calm);
    endtask

    task automatic cmp_field(input string name, input int unsigned e, input int unsigned a);
        if (e != a) begin
            if (n_fail < 50)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            n_fail++;
        end
    endtask

    // input side: drive items, predict at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                strip_byte(cur.b, cur.eot);
                if (cur.typed) begin
                    if (cur.n > 0) pending_out.push_back(cur.r0);
                    if (cur.n > 1) pending_out.push_back(cur.r1);
                end else begin
                    foreach (step_out[k]) pending_out.push_back(step_out[k]);
                end
            end
            if (!i_valid || !o_stall) begin
                if (feed_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur = feed_q.pop_front();
                    no_idle = cur.calm;
                    i_valid <= 1'b1;
                    i_in_byte <= cur.b;
                    i_end_of_text <= cur.eot;
                end else begin
                    i_valid <= 1'b0;
                    i_in_byte <= 8'($urandom_range(0, 255));
                    i_end_of_text <= 1'($urandom_range(0, 1));
                end
            end
        end
    end

    // output side: random stall, compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = mk(o_out_byte, o_is_text, o_last, o_unterminated, o_error_line);
                if (pending_out.size() == 0) begin
                    if (n_fail < 50)
                        $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    n_fail++;
                end else begin
                    want = pending_out.pop_front();
                    cmp_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
                    cmp_field("is_text", 32'(want.is_text), 32'(got.is_text));
                    cmp_field("last", 32'(want.last), 32'(got.last));
                    cmp_field("unterminated", 32'(want.unterminated), 32'(got.unterminated));
                    cmp_field("error_line", 32'(want.error_line), 32'(got.error_line));
                end
            end
            i_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        dir_tab[0]  = row(8'h00, 1'b1, 1'b1, 2'd1, mk(8'h00, 1'b0, 1'b1, 1'b0, 16'h0000), '0);
        dir_tab[1]  = row(8'h00, 1'b0, 1'b1, 2'd1, mk(8'h00, 1'b1, 1'b1, 1'b0, 16'h0000), '0);
        dir_tab[2]  = row(8'hFF, 1'b0, 1'b1, 2'd1, mk(8'hFF, 1'b1, 1'b1, 1'b0, 16'h0000), '0);
        dir_tab[3]  = row(cstrip_pkg::CH_SLASH, 1'b0, 1'b1, 2'd0, '0, '0);
        // slash after slash: first goes out, second is held
        dir_tab[4]  = row(cstrip_pkg::CH_SLASH, 1'b0, 1'b1, 2'd1,
                          mk(cstrip_pkg::CH_SLASH, 1'b1, 1'b1, 1'b0, 16'h0000), '0);
        // end of text flushes the held slash ahead of the status
        dir_tab[5]  = row(8'h00, 1'b1, 1'b1, 2'd2,
                          mk(cstrip_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0, 16'h0000),
                          mk(8'h00, 1'b0, 1'b1, 1'b0, 16'h0000));
        dir_tab[6]  = row(cstrip_pkg::CH_NL, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[7]  = row(cstrip_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[8]  = row(cstrip_pkg::CH_STAR, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[9]  = row(cstrip_pkg::CH_NL, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[10] = row(cstrip_pkg::CH_STAR, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[11] = row(cstrip_pkg::CH_STAR, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[12] = row(cstrip_pkg::CH_NL, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[13] = row(cstrip_pkg::CH_STAR, 1'b0, 1'b0, 2'd0, '0, '0);
        // text ends inside the comment opened on line 2; the byte is ignored
        dir_tab[14] = row(cstrip_pkg::CH_SLASH, 1'b1, 1'b1, 2'd1,
                          mk(8'h00, 1'b0, 1'b1, 1'b1, 16'd2), '0);
        dir_tab[15] = row(cstrip_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[16] = row(cstrip_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[17] = row(cstrip_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[18] = row(cstrip_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[19] = row(cstrip_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[20] = row(cstrip_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[21] = row(cstrip_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[22] = row(cstrip_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[23] = row(cstrip_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[24] = row(cstrip_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[25] = row(cstrip_pkg::CH_QUOTE, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[26] = row(cstrip_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[27] = row(8'h61, 1'b0, 1'b0, 2'd0, '0, '0);
        dir_tab[28] = row(8'hAB, 1'b1, 1'b1, 2'd1, mk(8'h00, 1'b0, 1'b1, 1'b0, 16'h0000), '0);
        for (int k = 0; k < N_DIR; k++)
            feed_q.push_back(dir_tab[k]);

        gen_source(RAND_ITEMS, 1'b0);
        // long stretch with no idling on either side
        gen_source(CALM_ITEMS, 1'b1);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || i_valid) @(posedge i_clk);
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (pending_out.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_out.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cstrip_pkg.sv
rtl/cstrip_scan.sv
rtl/cstrip_outq.sv
rtl/c_comment_stripper_core.sv
tb/sv/testbench.sv
